/* rtl/core/pbss_pkg.sv */
package pbss_pkg;

  localparam int POS_W = 16;
  localparam int SUM_W = 50;
  localparam int CNT_W = 17;
  localparam int CNT_FIELD_MAX = 131071;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic {
    REG_RING_CLOSED = 1'b0
  } reg_idx_t;

  localparam sum_t SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam sum_t SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  function automatic sum_t sat_add(input sum_t a, input sum_t p);
    logic signed [SUM_W:0] s;
    sum_t r;
    s = {a[SUM_W-1], a} + {p[SUM_W-1], p};
    if (s[SUM_W] != s[SUM_W-1]) begin
      r = s[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      r = s[SUM_W-1:0];
    end
    return r;
  endfunction

  function automatic cnt_t cnt_inc(input cnt_t c, input cnt_t lim);
    return (c < lim) ? c + cnt_t'(1) : c;
  endfunction

endpackage

/* rtl/core/pbss_prod.sv */
module pbss_prod #(
  parameter int DW = 17
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [DW-1:0]   d_x,
  input  logic signed [DW-1:0]   d_y,
  input  logic signed [DW-1:0]   d_z,
  output logic signed [2*DW-1:0] p_xy_r,
  output logic signed [2*DW-1:0] p_yz_r,
  output logic signed [2*DW-1:0] p_xz_r,
  output logic                   zero_r
);

  always_ff @(posedge clk) begin
    if (en) begin
      p_xy_r <= d_x * d_y;
      p_yz_r <= d_y * d_z;
      p_xz_r <= d_x * d_z;
      zero_r <= (d_x == '0) && (d_y == '0) && (d_z == '0);
    end
  end

endmodule

/* rtl/core/polymer_bond_stress_and_slack_unit.sv */
// path: stage 1, stage 2 products, finished chain, result register, then the out_ ports
// throughput: one monomer per cycle; input stalls only while one result waits in the
//   output register and a second finished chain waits behind it
// reset: synchronous, active low; clears ring_closed, the open chain state, the chain
//   sums and counters and every valid bit
module polymer_bond_stress_and_slack_unit #(
  parameter int COORD_BITS   = 16,
  parameter int MAX_MONOMERS = 65536
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [pbss_pkg::POS_W-1:0]   in_pos_x,
  input  logic signed [pbss_pkg::POS_W-1:0]   in_pos_y,
  input  logic signed [pbss_pkg::POS_W-1:0]   in_pos_z,
  input  logic                                in_last_monomer,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [pbss_pkg::SUM_W-1:0]   out_stress_xy,
  output logic signed [pbss_pkg::SUM_W-1:0]   out_stress_yz,
  output logic signed [pbss_pkg::SUM_W-1:0]   out_stress_xz,
  output logic [pbss_pkg::CNT_W-1:0]          out_slack_bonds,
  output logic [pbss_pkg::CNT_W-1:0]          out_bond_count,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [pbss_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [pbss_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [pbss_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);

  import pbss_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int CNT_LIMIT_I = (MAX_MONOMERS < CNT_FIELD_MAX) ? MAX_MONOMERS : CNT_FIELD_MAX;
  localparam cnt_t CNT_LIMIT = CNT_W'(CNT_LIMIT_I);

  // config
  logic ring_closed_r;
  logic cfg_sel;

  assign cfg_pready = 1'b1;
  assign cfg_sel = (cfg_paddr[CFG_ADDR_W-1] == REG_RING_CLOSED);
  assign cfg_prdata = cfg_sel ? {{(CFG_DATA_W-1){1'b0}}, ring_closed_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_closed_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_sel) begin
      ring_closed_r <= cfg_pwdata[0];
    end
  end

  // flow control
  logic adv;
  logic in_acc;
  logic fin_valid_r;
  logic out_valid_r;
  logic fin_move;

  assign fin_move = fin_valid_r && (!out_valid_r || !out_stall);
  assign adv = !fin_valid_r || fin_move;
  assign in_stall = !adv;
  assign in_acc = in_valid && adv;

  // coordinate capture
  logic signed [COORD_BITS-1:0] raw_x, raw_y, raw_z;

  generate
    if (COORD_BITS <= POS_W) begin : g_narrow
      assign raw_x = in_pos_x[COORD_BITS-1:0];
      assign raw_y = in_pos_y[COORD_BITS-1:0];
      assign raw_z = in_pos_z[COORD_BITS-1:0];
    end else begin : g_wide
      assign raw_x = {{(COORD_BITS-POS_W){1'b0}}, in_pos_x};
      assign raw_y = {{(COORD_BITS-POS_W){1'b0}}, in_pos_y};
      assign raw_z = {{(COORD_BITS-POS_W){1'b0}}, in_pos_z};
    end
  endgenerate

  logic signed [DW-1:0] cur_x, cur_y, cur_z;
  logic signed [DW-1:0] first_x, first_y, first_z;
  logic signed [DW-1:0] first_x_r, first_y_r, first_z_r;
  logic signed [DW-1:0] prev_x_r, prev_y_r, prev_z_r;
  logic                 have_prev_r;

  assign cur_x = DW'(raw_x);
  assign cur_y = DW'(raw_y);
  assign cur_z = DW'(raw_z);
  assign first_x = have_prev_r ? first_x_r : cur_x;
  assign first_y = have_prev_r ? first_y_r : cur_y;
  assign first_z = have_prev_r ? first_z_r : cur_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
    end else if (in_acc) begin
      have_prev_r <= !in_last_monomer;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      prev_x_r  <= cur_x;
      prev_y_r  <= cur_y;
      prev_z_r  <= cur_z;
      first_x_r <= first_x;
      first_y_r <= first_y;
      first_z_r <= first_z;
    end
  end

  // stage 1: bond differences
  logic                 s1_valid_r, s1_b1_r, s1_b2_r, s1_last_r;
  logic signed [DW-1:0] s1_d1x_r, s1_d1y_r, s1_d1z_r;
  logic signed [DW-1:0] s1_d2x_r, s1_d2y_r, s1_d2z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_b1_r   <= have_prev_r;
      s1_b2_r   <= in_last_monomer && ring_closed_r;
      s1_last_r <= in_last_monomer;
      s1_d1x_r  <= cur_x - prev_x_r;
      s1_d1y_r  <= cur_y - prev_y_r;
      s1_d1z_r  <= cur_z - prev_z_r;
      s1_d2x_r  <= first_x - cur_x;
      s1_d2y_r  <= first_y - cur_y;
      s1_d2z_r  <= first_z - cur_z;
    end
  end

  // stage 2: products
  logic                 s2_valid_r, s2_b1_r, s2_b2_r, s2_last_r;
  logic signed [PW-1:0] p1_xy, p1_yz, p1_xz, p2_xy, p2_yz, p2_xz;
  logic                 z1, z2;

  pbss_prod #(.DW(DW)) u_prod_bond (
    .clk    (clk),
    .en     (adv),
    .d_x    (s1_d1x_r),
    .d_y    (s1_d1y_r),
    .d_z    (s1_d1z_r),
    .p_xy_r (p1_xy),
    .p_yz_r (p1_yz),
    .p_xz_r (p1_xz),
    .zero_r (z1)
  );

  pbss_prod #(.DW(DW)) u_prod_close (
    .clk    (clk),
    .en     (adv),
    .d_x    (s1_d2x_r),
    .d_y    (s1_d2y_r),
    .d_z    (s1_d2z_r),
    .p_xy_r (p2_xy),
    .p_yz_r (p2_yz),
    .p_xz_r (p2_xz),
    .zero_r (z2)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_b1_r   <= s1_b1_r;
      s2_b2_r   <= s1_b2_r;
      s2_last_r <= s1_last_r;
    end
  end

  // stage 3: chain accumulators
  sum_t acc_xy_r, acc_yz_r, acc_xz_r;
  cnt_t slack_cnt_r, bond_cnt_r;
  sum_t a_xy, a_yz, a_xz;
  cnt_t a_slack, a_bond;

  always_comb begin
    a_xy    = acc_xy_r;
    a_yz    = acc_yz_r;
    a_xz    = acc_xz_r;
    a_slack = slack_cnt_r;
    a_bond  = bond_cnt_r;
    if (s2_b1_r) begin
      a_xy   = sat_add(acc_xy_r, SUM_W'(p1_xy));
      a_yz   = sat_add(acc_yz_r, SUM_W'(p1_yz));
      a_xz   = sat_add(acc_xz_r, SUM_W'(p1_xz));
      a_bond = cnt_inc(bond_cnt_r, CNT_LIMIT);
      if (z1) begin
        a_slack = cnt_inc(slack_cnt_r, CNT_LIMIT);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_xy_r    <= '0;
      acc_yz_r    <= '0;
      acc_xz_r    <= '0;
      slack_cnt_r <= '0;
      bond_cnt_r  <= '0;
    end else if (adv && s2_valid_r) begin
      if (s2_last_r) begin
        acc_xy_r    <= '0;
        acc_yz_r    <= '0;
        acc_xz_r    <= '0;
        slack_cnt_r <= '0;
        bond_cnt_r  <= '0;
      end else begin
        acc_xy_r    <= a_xy;
        acc_yz_r    <= a_yz;
        acc_xz_r    <= a_xz;
        slack_cnt_r <= a_slack;
        bond_cnt_r  <= a_bond;
      end
    end
  end

  // finished chain, closing bond still pending
  sum_t fin_xy_r, fin_yz_r, fin_xz_r;
  sum_t fin_p_xy_r, fin_p_yz_r, fin_p_xz_r;
  cnt_t fin_slack_r, fin_bond_r;
  logic fin_b2_r, fin_z2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_valid_r <= 1'b0;
    end else if (adv) begin
      fin_valid_r <= s2_valid_r && s2_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fin_xy_r    <= a_xy;
      fin_yz_r    <= a_yz;
      fin_xz_r    <= a_xz;
      fin_slack_r <= a_slack;
      fin_bond_r  <= a_bond;
      fin_p_xy_r  <= SUM_W'(p2_xy);
      fin_p_yz_r  <= SUM_W'(p2_yz);
      fin_p_xz_r  <= SUM_W'(p2_xz);
      fin_b2_r    <= s2_b2_r;
      fin_z2_r    <= z2;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_move) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_move) begin
      if (fin_b2_r) begin
        out_stress_xy   <= sat_add(fin_xy_r, fin_p_xy_r);
        out_stress_yz   <= sat_add(fin_yz_r, fin_p_yz_r);
        out_stress_xz   <= sat_add(fin_xz_r, fin_p_xz_r);
        out_bond_count  <= cnt_inc(fin_bond_r, CNT_LIMIT);
        out_slack_bonds <= fin_z2_r ? cnt_inc(fin_slack_r, CNT_LIMIT) : fin_slack_r;
      end else begin
        out_stress_xy   <= fin_xy_r;
        out_stress_yz   <= fin_yz_r;
        out_stress_xz   <= fin_xz_r;
        out_bond_count  <= fin_bond_r;
        out_slack_bonds <= fin_slack_r;
      end
    end
  end

  assign out_valid = out_valid_r;

  a_slack_le_bonds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_slack_bonds <= out_bond_count))
    else $error("zero-length bond count above bond count");

  a_bond_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (bond_cnt_r <= CNT_LIMIT) && (slack_cnt_r <= bond_cnt_r))
    else $error("chain counters out of range");

  a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_valid_r && out_valid_r && out_stall) |-> in_stall)
    else $error("input taken while finished chain is blocked");

  a_last_clears_chain: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_last_monomer) |=> !have_prev_r)
    else $error("chain not restarted after last monomer");

  a_close_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_b2_r) |-> s1_last_r)
    else $error("closing bond on a monomer that is not last");

endmodule

/* tb/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pbss_pkg::*;

  localparam int MAX_MON         = 65536;
  localparam int CNT_CAP         = (MAX_MON < CNT_FIELD_MAX) ? MAX_MON : CNT_FIELD_MAX;
  localparam int SETTLE_CYCLES   = 8;
  localparam int WATCHDOG_CYCLES = 5000;
  localparam int RANDOM_PHASE    = 90;

  typedef logic signed [POS_W-1:0] coord_t;

  localparam coord_t COORD_MIN = {1'b1, {(POS_W-1){1'b0}}};
  localparam coord_t COORD_MAX = {1'b0, {(POS_W-1){1'b1}}};

  typedef struct {
    sum_t xy;
    sum_t yz;
    sum_t xz;
    cnt_t slack;
    cnt_t bonds;
  } chain_sums_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  coord_t                in_pos_x;
  coord_t                in_pos_y;
  coord_t                in_pos_z;
  logic                  in_last_monomer;
  logic                  out_valid;
  logic                  out_stall;
  sum_t                  out_stress_xy;
  sum_t                  out_stress_yz;
  sum_t                  out_stress_xz;
  cnt_t                  out_slack_bonds;
  cnt_t                  out_bond_count;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  polymer_bond_stress_and_slack_unit #(
    .COORD_BITS  (POS_W),
    .MAX_MONOMERS(MAX_MON)
  ) u_top (.*);

  // chain state mirrored on the testbench side
  coord_t      head_x, head_y, head_z;
  coord_t      tail_x, tail_y, tail_z;
  bit          chain_open;
  sum_t        acc_xy, acc_yz, acc_xz;
  cnt_t        slack_cnt, bond_cnt;
  bit          ring_mode;
  chain_sums_t pending_sums[$];

  int mismatch_count;
  int idle_cycles;
  int long_hold;
  bit in_idle_on;
  bit rx_idle_on;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic sum_t clamp_sum(input sum_t acc, input longint prod);
    longint s;
    s = longint'(acc) + prod;
    if (s > longint'(SUM_MAX)) return SUM_MAX;
    if (s < longint'(SUM_MIN)) return SUM_MIN;
    return sum_t'(s);
  endfunction

  function automatic void add_bond(input coord_t fx, input coord_t fy, input coord_t fz,
                                   input coord_t tx, input coord_t ty, input coord_t tz);
    longint dx, dy, dz;
    dx = longint'(tx) - longint'(fx);
    dy = longint'(ty) - longint'(fy);
    dz = longint'(tz) - longint'(fz);
    acc_xy = clamp_sum(acc_xy, dx * dy);
    acc_yz = clamp_sum(acc_yz, dy * dz);
    acc_xz = clamp_sum(acc_xz, dx * dz);
    if (dx == 0 && dy == 0 && dz == 0 && slack_cnt < CNT_CAP) slack_cnt = slack_cnt + 1'b1;
    if (bond_cnt < CNT_CAP) bond_cnt = bond_cnt + 1'b1;
  endfunction

  function automatic void clear_chain();
    head_x = '0; head_y = '0; head_z = '0;
    tail_x = '0; tail_y = '0; tail_z = '0;
    chain_open = 1'b0;
    acc_xy = '0; acc_yz = '0; acc_xz = '0;
    slack_cnt = '0; bond_cnt = '0;
  endfunction

  function automatic void accumulate_monomer(input coord_t x, input coord_t y, input coord_t z,
                                             input bit last);
    chain_sums_t r;
    if (chain_open) begin
      add_bond(tail_x, tail_y, tail_z, x, y, z);
    end else begin
      head_x = x; head_y = y; head_z = z;
      chain_open = 1'b1;
    end
    tail_x = x; tail_y = y; tail_z = z;
    if (last) begin
      if (ring_mode) add_bond(x, y, z, head_x, head_y, head_z);
      r.xy = acc_xy;
      r.yz = acc_yz;
      r.xz = acc_xz;
      r.slack = slack_cnt;
      r.bonds = bond_cnt;
      pending_sums.push_back(r);
      clear_chain();
    end
  endfunction

  function automatic void check_field(input string name, input logic signed [63:0] want,
                                      input logic signed [63:0] got);
    if (got !== want) begin
      $error("%s expected %0d got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  function automatic coord_t pick_coord();
    case ($urandom_range(0, 5))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return '0;
      3: return '1;
      default: return coord_t'($urandom);
    endcase
  endfunction

  // result checker and watchdog
  always @(posedge clk) begin
    chain_sums_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_sums.size() == 0) begin
        $error("unexpected result: stress_xy %0d bond_count %0d", out_stress_xy,
               out_bond_count);
        mismatch_count++;
      end else begin
        want = pending_sums.pop_front();
        check_field("stress_xy", want.xy, out_stress_xy);
        check_field("stress_yz", want.yz, out_stress_yz);
        check_field("stress_xz", want.xz, out_stress_xz);
        check_field("slack_bonds", want.slack, out_slack_bonds);
        check_field("bond_count", want.bonds, out_bond_count);
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("[polymer_bond_stress_and_slack_unit] ERROR");
      $finish;
    end
  end

  // receiver side: random stall bursts, or one long hold when requested
  initial begin : rx_side
    int n;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold > 0) begin
        n = long_hold;
        long_hold = 0;
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_monomer(input coord_t x, input coord_t y, input coord_t z,
                              input bit last);
    if (in_idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_pos_x        <= x;
    in_pos_y        <= y;
    in_pos_z        <= z;
    in_last_monomer <= last;
    do @(posedge clk); while (in_stall);
    accumulate_monomer(x, y, z, last);
  endtask

  task automatic drain_chains();
    in_valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_ring(input bit mode);
    logic [CFG_DATA_W-1:0] data;
    data = $urandom_range(0, 1) ? CFG_DATA_W'($urandom) : '0;
    data[0] = mode;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'(4 * int'(REG_RING_CLOSED));
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    ring_mode = mode;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_single_monomer();
    drain_chains();
    write_ring(1'b0);
    send_monomer(pick_coord(), pick_coord(), pick_coord(), 1'b1);
    drain_chains();
    write_ring(1'b1);
    send_monomer(pick_coord(), pick_coord(), pick_coord(), 1'b1);
    drain_chains();
  endtask

  task automatic test_extreme_coords();
    coord_t pts[7][3];
    int m, k;
    pts = '{'{COORD_MIN, COORD_MIN, COORD_MIN}, '{COORD_MAX, COORD_MAX, COORD_MAX},
            '{COORD_MAX, COORD_MIN, '0}, '{'0, '0, '0}, '{'0, '0, '0},
            '{'1, '1, '1}, '{coord_t'(1), coord_t'(1), coord_t'(1)}};
    for (m = 0; m < 2; m++) begin
      drain_chains();
      write_ring(m[0]);
      for (k = 0; k < 7; k++) send_monomer(pts[k][0], pts[k][1], pts[k][2], k == 6);
    end
    drain_chains();
  endtask

  task automatic test_ring_switch_mid_chain();
    int m, k;
    for (m = 0; m < 2; m++) begin
      drain_chains();
      write_ring(m[0]);
      for (k = 0; k < 3; k++) send_monomer(pick_coord(), pick_coord(), pick_coord(), 1'b0);
      drain_chains();
      write_ring(!m[0]);
      for (k = 0; k < 2; k++) send_monomer(pick_coord(), pick_coord(), pick_coord(), k == 1);
    end
    drain_chains();
  endtask

  task automatic test_large_bonds();
    int k;
    drain_chains();
    write_ring(1'b1);
    // largest bonds of one sign
    for (k = 0; k < 20; k++) begin
      if (k % 2 == 0) send_monomer(COORD_MIN, COORD_MIN, COORD_MAX, 1'b0);
      else send_monomer(COORD_MAX, COORD_MAX, COORD_MIN, 1'b0);
    end
    // opposite sign pulls xy and xz back
    for (k = 0; k < 20; k++) begin
      if (k % 2 == 0) send_monomer(COORD_MIN, COORD_MAX, COORD_MIN, 1'b0);
      else send_monomer(COORD_MAX, COORD_MIN, COORD_MAX, k == 19);
    end
    drain_chains();
  endtask

  task automatic test_output_backpressure();
    int k;
    drain_chains();
    in_idle_on = 1'b0;
    long_hold = 400;
    for (k = 0; k < 12; k++) begin
      send_monomer(pick_coord(), pick_coord(), pick_coord(), 1'b0);
      send_monomer(pick_coord(), pick_coord(), pick_coord(), 1'b1);
    end
    in_idle_on = 1'b1;
    drain_chains();
  endtask

  task automatic test_random_chains(input int budget, input bit mode);
    coord_t x, y, z;
    int sent, len, style, k;
    drain_chains();
    write_ring(mode);
    sent = 0;
    while (sent < budget) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8);
      style = $urandom_range(0, 2);
      x = pick_coord();
      y = pick_coord();
      z = pick_coord();
      for (k = 0; k < len; k++) begin
        if (k > 0) begin
          case (style)
            0: begin
              x = coord_t'($urandom); y = coord_t'($urandom); z = coord_t'($urandom);
            end
            1: begin
              // lattice walk, zero steps give slack bonds
              x = x + coord_t'(int'($urandom_range(0, 2)) - 1);
              y = y + coord_t'(int'($urandom_range(0, 2)) - 1);
              z = z + coord_t'(int'($urandom_range(0, 2)) - 1);
            end
            default: begin
              x = pick_coord(); y = pick_coord(); z = pick_coord();
            end
          endcase
        end
        send_monomer(x, y, z, k == len - 1);
        sent++;
      end
    end
  endtask

  initial begin
    clear_chain();
    ring_mode       = 1'b0;
    mismatch_count  = 0;
    idle_cycles     = 0;
    long_hold       = 0;
    in_idle_on      = 1'b1;
    rx_idle_on      = 1'b1;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_pos_x        = '0;
    in_pos_y        = '0;
    in_pos_z        = '0;
    in_last_monomer = 1'b0;
    cfg_psel        = 1'b0;
    cfg_penable     = 1'b0;
    cfg_pwrite      = 1'b0;
    cfg_paddr       = '0;
    cfg_pwdata      = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_monomer();
    test_extreme_coords();
    test_ring_switch_mid_chain();
    test_output_backpressure();
    test_large_bonds();
    test_random_chains(RANDOM_PHASE, 1'b0);
    test_random_chains(RANDOM_PHASE, 1'b1);
    test_random_chains(RANDOM_PHASE, 1'b0);
    test_random_chains(RANDOM_PHASE, 1'b1);
    in_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    test_random_chains(RANDOM_PHASE, 1'($urandom_range(0, 1)));
    drain_chains();

    if (mismatch_count == 0) begin
      $display("[polymer_bond_stress_and_slack_unit] OK");
    end else begin
      $display("[polymer_bond_stress_and_slack_unit] ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/pbss_pkg.sv
rtl/core/pbss_prod.sv
rtl/core/polymer_bond_stress_and_slack_unit.sv
tb/tb.sv
